[sv/flc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants of the FIR low-pass convolution block
// Field widths, payload structs, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package flc_pkg;

  // Field widths
  localparam int COEF_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int TAP_IDX_W  = 6;
  localparam int TAPS_W     = 7;
  localparam int DIV_W      = 25;
  localparam int OUT_W      = 16;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int FRAC_BITS  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIV_W;

  localparam logic [TAPS_W-1:0] TAPS_RESET    = 7'd64;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 25'd1;

  // Saturation limits on the quotient magnitude
  localparam int POS_LIMIT = 32767;
  localparam int NEG_LIMIT = 32768;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPS_IN_USE    = 1'b0,
    REG_LENGTH_DIVISOR = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_COEF   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_EMIT,
    ST_SHIFT
  } flc_state_e;

  typedef struct packed {
    logic                       mode;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [COEF_W-1:0]   coefficient;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } flc_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    last_output;
  } flc_out_t;

endpackage
`default_nettype wire

[sv/flc_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flc_stream_if: valid/ready stream channel
// Carries one payload per transaction; source drives valid and data.
// ----------------------------------------------------------------------------
interface flc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/fir_lowpass_full_convolution.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a sample runs the shared MAC over taps_in_use taps, then the serial divider over
//   the ACC_W-bit magnitude (54 bits with 64 taps), then the emit. A last sample adds
//   taps_in_use - 1 tail outputs, each run through the MAC and divider. A new sample or
//   coefficient is taken only while idle, once the previous output and tail are emitted;
//   an output stall holds the emit. Reset: the delay line reads as zero at once (fill count);
//   coefficients undefined until loaded; taps_in_use resets to 64, length_divisor to 1.
// ----------------------------------------------------------------------------
// fir_lowpass_full_convolution: full-length FIR convolution, serial MAC
// One shared 32x16 multiplier walks the taps, a restoring divider scales the
// sum, and a small sequencer emits the tail outputs after a last sample.
// ----------------------------------------------------------------------------
module fir_lowpass_full_convolution #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [flc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [flc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  flc_stream_if.sink                          in_i,
  flc_stream_if.source                        out_o
);
  import flc_pkg::*;

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int HI_W   = ACC_W - FRAC_BITS;
  localparam int DCNT_W = $clog2(ACC_W);

  // Sequencer
  flc_state_e state_q, state_d;

  // Configuration registers
  logic [TAPS_W-1:0] taps_q;
  logic [DIV_W-1:0]  dvs_q;
  logic [TW-1:0]     taps_eff;
  logic [DIV_W-1:0]  dvs_eff;

  // Storage
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] dly_mem  [MAX_TAPS];
  logic [AW-1:0]              wp_q, wp_inc;
  logic [TW-1:0]              fill_q;

  // MAC pipeline
  logic [TW-1:0]              iss_q;
  logic                       iss_act;
  logic [AW-1:0]              iss_idx;
  logic [AW-1:0]              dly_raddr;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [SAMPLE_W-1:0] dly_rd_q;
  logic                       s1_vld_q, s1_live_q, s2_vld_q;
  logic signed [SAMPLE_W-1:0] smp_sel;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]           acc_mag;
  logic                       mac_done;

  // Divider
  logic [ACC_W-1:0]  quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W:0]    div_shl;
  logic [DIV_W+1:0]  div_diff;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_last;
  logic              neg_q;

  // Tail and output
  logic [TW-1:0]           tail_q;
  logic                    last_q;
  logic                    out_vld_q;
  flc_out_t                out_q;
  logic [HI_W-1:0]         quo_hi;
  logic signed [OUT_W-1:0] filt;
  logic                    out_free;
  logic                    out_last;

  // Control strobes
  logic in_rdy, push, coef_we, mac_start, shift_zero, div_start, div_step, emit;
  logic tap_ok, dly_we;
  logic signed [SAMPLE_W-1:0] dly_wdata;

  // Clamp configuration to the legal ranges
  always_comb begin
    if (taps_q == '0) begin
      taps_eff = TW'(1);
    end else if (taps_q > TAPS_W'(MAX_TAPS)) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = taps_q[TW-1:0];
    end
    dvs_eff = (dvs_q == '0) ? DIV_W'(1) : dvs_q;
  end

  assign tap_ok   = TAPS_W'(in_i.data.tap_index) < TAPS_W'(MAX_TAPS);
  assign wp_inc   = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
  assign iss_act  = (state_q == ST_MAC) && (iss_q < taps_eff);
  assign iss_idx  = iss_q[AW-1:0];
  assign mac_done = (iss_q == taps_eff) && !s1_vld_q && !s2_vld_q;
  assign div_last = (div_cnt_q == DCNT_W'(ACC_W - 1));
  assign out_free = !out_vld_q || out_o.ready;
  assign out_last = last_q && (tail_q == '0);

  // Age to circular buffer address: newest entry sits at the write pointer
  always_comb begin
    if (wp_q >= iss_idx) begin
      dly_raddr = wp_q - iss_idx;
    end else begin
      dly_raddr = AW'((AW+1)'(wp_q) + (AW+1)'(MAX_TAPS) - (AW+1)'(iss_idx));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && (in_i.data.mode == MODE_SAMPLE)) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (mac_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = (tail_q != '0) ? ST_SHIFT : ST_IDLE;
      end
      ST_SHIFT: begin
        state_d = ST_MAC;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_rdy     = 1'b0;
    push       = 1'b0;
    coef_we    = 1'b0;
    mac_start  = 1'b0;
    shift_zero = 1'b0;
    div_start  = 1'b0;
    div_step   = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_i.valid) begin
          if (in_i.data.mode == MODE_SAMPLE) begin
            push      = 1'b1;
            mac_start = 1'b1;
          end else begin
            coef_we = tap_ok;
          end
        end
      end
      ST_MAC:  div_start = mac_done;
      ST_DIV:  div_step  = 1'b1;
      ST_EMIT: emit      = out_free;
      ST_SHIFT: begin
        shift_zero = 1'b1;
        mac_start  = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Delay line write: new sample on push, zero during the tail
  assign dly_we    = push || shift_zero;
  assign dly_wdata = push ? in_i.data.sample : '0;

  // Coefficient and delay line memories
  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[in_i.data.tap_index[AW-1:0]] <= in_i.data.coefficient;
    if (dly_we)  dly_mem[wp_inc] <= dly_wdata;
    coef_rd_q <= coef_mem[iss_idx];
    dly_rd_q  <= dly_mem[dly_raddr];
  end

  // Shared multiplier: entries older than the fill count read as zero
  assign smp_sel = s1_live_q ? dly_rd_q : '0;
  assign prod_d  = PROD_W'(coef_rd_q) * PROD_W'(smp_sel);
  assign acc_mag = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;

  // Divider step: shift in the next dividend bit, subtract where it fits
  assign div_shl  = {rem_q, quo_q[ACC_W-1]};
  assign div_diff = {1'b0, div_shl} - {2'b00, dvs_eff};

  // Drop the fraction, restore the sign and saturate
  assign quo_hi = quo_q[ACC_W-1:FRAC_BITS];
  always_comb begin
    if (neg_q) begin
      filt = (quo_hi > HI_W'(NEG_LIMIT)) ? OUT_MIN : -quo_hi[OUT_W-1:0];
    end else begin
      filt = (quo_hi > HI_W'(POS_LIMIT)) ? OUT_MAX : quo_hi[OUT_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      taps_q    <= TAPS_RESET;
      dvs_q     <= DIVISOR_RESET;
      wp_q      <= '0;
      fill_q    <= '0;
      iss_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      div_cnt_q <= '0;
      tail_q    <= '0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_TAPS_IN_USE:    taps_q <= cfg_wdata_i[TAPS_W-1:0];
          REG_LENGTH_DIVISOR: dvs_q  <= cfg_wdata_i[DIV_W-1:0];
          default: ;
        endcase
      end

      // Advance the delay line; clear it after the final tail output
      if (dly_we) begin
        wp_q <= wp_inc;
        if (fill_q != TW'(MAX_TAPS)) fill_q <= fill_q + TW'(1);
      end else if (emit && out_last) begin
        fill_q <= '0;
      end

      // Tap issue counter and pipeline valids
      if (mac_start) begin
        iss_q <= '0;
      end else if (iss_act) begin
        iss_q <= iss_q + TW'(1);
      end
      s1_vld_q <= iss_act;
      s2_vld_q <= s1_vld_q;

      // Divider bit counter
      if (div_start) begin
        div_cnt_q <= '0;
      end else if (div_step) begin
        div_cnt_q <= div_cnt_q + DCNT_W'(1);
      end

      // Tail bookkeeping
      if (push) begin
        last_q <= in_i.data.last_sample;
        tail_q <= in_i.data.last_sample ? taps_eff - TW'(1) : '0;
      end else if (emit && (tail_q != '0)) begin
        tail_q <= tail_q - TW'(1);
      end

      // Output register
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    s1_live_q <= iss_q < fill_q;
    prod_q    <= prod_d;
    if (mac_start) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (div_start) begin
      quo_q <= acc_mag;
      rem_q <= '0;
      neg_q <= acc_q[ACC_W-1];
    end else if (div_step) begin
      quo_q <= {quo_q[ACC_W-2:0], ~div_diff[DIV_W+1]};
      rem_q <= div_diff[DIV_W+1] ? div_shl[DIV_W-1:0] : div_diff[DIV_W-1:0];
    end
    if (emit) begin
      out_q.filtered    <= filt;
      out_q.last_output <= out_last;
    end
  end

  // Checks
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TW'(MAX_TAPS))
    else $error("delay line fill count beyond depth");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_last |=> fill_q == '0)
    else $error("delay line not cleared after final output");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |-> !emit)
    else $error("pending result overwritten");

  a_taps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taps_eff != '0 && taps_eff <= TW'(MAX_TAPS))
    else $error("effective tap count out of range");

endmodule
`default_nettype wire
